FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define AST_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: hw/rtl/bhpq_pkg.sv
// Shared action and status codes for the heap priority queue.
`default_nettype none
package bhpq_pkg;
    localparam logic [1:0] ACT_ENQ = 2'd0;
    localparam logic [1:0] ACT_DEQ = 2'd1;
    localparam logic [1:0] ACT_LOWER = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_EMPTY = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_RAISED = 3'd3;
    localparam logic [2:0] ST_FULL = 3'd4;
endpackage
`default_nettype wire

FILE: hw/rtl/binary_heap_priority_queue_unit.sv
// Top level of the binary min-heap priority queue.
// Usage:
//   Input channel: i_valid/o_stall carries one action beat (action, tag,
//   priority_req). Output channel: o_valid/i_stall carries one result beat
//   per action (status, out_tag, head, count).
//   Storage is a chain of CAPACITY cells closed into a ring; while an action
//   runs all cells shift one place per cycle, so every heap index passes the
//   chain tail once per rotation.
//   Each action but full, empty and clear makes one scan rotation, then the sift:
//   - enqueue/lower: one rotation per sift-up swap plus a final compare.
//   - dequeue: one rotation per sift-down swap plus a final compare.
//   Full, empty and clear skip the scan; a priority change that is not
//   found or would raise the priority ends after the scan. At CAPACITY 64
//   a sift makes at most six swaps. o_stall falls in the same cycle that
//   o_valid rises.
//   Reset clears the count and all cell valid bits; the queue is empty.
//   The result is held in an output register; while i_stall holds it a new
//   action may start, but its result waits in the done state (o_stall high).
`default_nettype none
`include "assert_macros.svh"
module binary_heap_priority_queue_unit #(
    parameter int CAPACITY = 64,
    parameter int TAG_BITS = 16,
    parameter int PRIO_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [1:0]           i_action,
    input  wire logic [15:0]          i_tag,
    input  wire logic [15:0]          i_priority_req,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [2:0]                o_status,
    output logic [15:0]               o_out_tag,
    output logic [15:0]               o_head_tag,
    output logic [15:0]               o_head_priority,
    output logic                      o_head_valid,
    output logic [6:0]                o_count
);
    import bhpq_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = IW + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_UP   = 3'd2;
    localparam logic [2:0] S_DOWN = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    // Chain: cell k feeds cell k+1; cell CAPACITY-1 wraps back to cell 0.
    // The cell at the chain tail always holds heap index r_rot.
    logic [CAPACITY-1:0]  c_valid;
    logic [TAG_BITS-1:0]  c_tag  [CAPACITY];
    logic [PRIO_BITS-1:0] c_prio [CAPACITY];
    logic                 in_valid;
    logic [TAG_BITS-1:0]  in_tag;
    logic [PRIO_BITS-1:0] in_prio;
    logic                 shift;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic                 cv;
            logic [TAG_BITS-1:0]  ct;
            logic [PRIO_BITS-1:0] cp;
            if (g == 0) begin : g_first
                assign cv = in_valid;
                assign ct = in_tag;
                assign cp = in_prio;
            end else begin : g_rest
                assign cv = c_valid[g-1];
                assign ct = c_tag[g-1];
                assign cp = c_prio[g-1];
            end
            bhpq_cell #(.TAG_BITS(TAG_BITS), .PRIO_BITS(PRIO_BITS)) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_load (shift),
                .i_valid(cv),
                .i_tag  (ct),
                .i_prio (cp),
                .o_valid(c_valid[g]),
                .o_tag  (c_tag[g]),
                .o_prio (c_prio[g])
            );
        end
    endgenerate

    // Entry leaving the chain tail has heap index r_rot.
    logic                 t_valid;
    logic [TAG_BITS-1:0]  t_tag;
    logic [PRIO_BITS-1:0] t_prio;
    assign t_valid = c_valid[CAPACITY-1];
    assign t_tag   = c_tag[CAPACITY-1];
    assign t_prio  = c_prio[CAPACITY-1];

    logic [2:0]           r_state;
    logic [IW-1:0]        r_rot;      // heap index at the chain tail
    logic [CW-1:0]        r_count;
    logic [1:0]           r_act;
    logic [TAG_BITS-1:0]  r_tag;
    logic [PRIO_BITS-1:0] r_prio;
    logic [IW-1:0]        r_pos;      // node under sift
    logic                 r_found;
    logic [2:0]           r_status;
    logic [TAG_BITS-1:0]  r_removed;
    // Sift working registers gathered during a rotation.
    logic [TAG_BITS-1:0]  r_nt, r_lt, r_rt;
    logic [PRIO_BITS-1:0] r_np, r_lp, r_rp;
    logic                 r_swap;     // pass rewrites slots r_sa and r_sb (may be the same slot)
    logic [IW-1:0]        r_sa, r_sb;
    logic [TAG_BITS-1:0]  r_at, r_bt;
    logic [PRIO_BITS-1:0] r_ap, r_bp;
    logic                 r_ovalid;
    logic [2:0]           r_ostatus;
    logic [15:0]          r_otag, r_htag, r_hprio;
    logic                 r_hvalid;
    logic [6:0]           r_ocount;

    function automatic logic ahead_of(input logic [TAG_BITS-1:0] at,
                                      input logic [PRIO_BITS-1:0] ap,
                                      input logic [TAG_BITS-1:0] bt,
                                      input logic [PRIO_BITS-1:0] bp);
        ahead_of = (ap != bp) ? (ap < bp) : (at < bt);
    endfunction

    logic [IW:0]   w_left, w_right;
    logic [IW-1:0] w_parent;
    assign w_left   = {r_pos, 1'b1};
    assign w_right  = {r_pos, 1'b0} + CW'(2);
    assign w_parent = (r_pos - 1'b1) >> 1;

    logic in_idx_valid;
    assign in_idx_valid = ({1'b0, r_rot} < r_count);
    logic at_end;
    assign at_end = (r_rot == IW'(CAPACITY - 1));

    // Tag match of the scan for a priority change.
    logic w_hit;
    assign w_hit = (r_act == ACT_LOWER) && t_valid && in_idx_valid && !r_found
                   && (t_tag == r_tag);

    // Gathered values, taken straight from the ring when the index is at the tail.
    logic node_hit, aux_hit, right_hit;
    assign node_hit  = (r_rot == r_pos);
    assign aux_hit   = (r_state == S_UP) ? (r_rot == w_parent) : ({1'b0, r_rot} == w_left);
    assign right_hit = ({1'b0, r_rot} == w_right);

    logic [TAG_BITS-1:0]  e_nt, e_lt, e_rt;
    logic [PRIO_BITS-1:0] e_np, e_lp, e_rp;
    assign e_nt = node_hit  ? in_tag  : r_nt;
    assign e_np = node_hit  ? in_prio : r_np;
    assign e_lt = aux_hit   ? in_tag  : r_lt;
    assign e_lp = aux_hit   ? in_prio : r_lp;
    assign e_rt = right_hit ? in_tag  : r_rt;
    assign e_rp = right_hit ? in_prio : r_rp;

    logic w_lv, w_rv;
    assign w_lv = (w_left < r_count);
    assign w_rv = (w_right < r_count);

    assign shift = (r_state == S_SCAN) || (r_state == S_UP) || (r_state == S_DOWN);

    // Value written back into the chain head this cycle.
    always_comb begin
        in_valid = in_idx_valid;
        in_tag   = t_tag;
        in_prio  = t_prio;
        if (r_state == S_SCAN) begin
            if (w_hit && r_prio <= t_prio) begin
                in_prio = r_prio;
            end
        end else if (r_swap) begin
            if (r_rot == r_sa) begin
                in_tag = r_at; in_prio = r_ap;
            end else if (r_rot == r_sb) begin
                in_tag = r_bt; in_prio = r_bp;
            end
        end
    end

    logic can_out;
    assign can_out = !r_ovalid || !i_stall;
    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_rot    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_DONE && can_out) r_ovalid <= 1'b1;
            else if (!i_stall) r_ovalid <= 1'b0;
            if (shift) r_rot <= at_end ? '0 : r_rot + 1'b1;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_act     <= i_action;
                        r_tag     <= TAG_BITS'(i_tag);
                        r_prio    <= PRIO_BITS'(i_priority_req);
                        r_found   <= 1'b0;
                        r_removed <= '0;
                        r_status  <= ST_OK;
                        r_swap    <= 1'b0;
                        unique case (i_action)
                            ACT_ENQ: begin
                                if (r_count >= CW'(CAPACITY)) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            ACT_DEQ: begin
                                if (r_count == '0) begin
                                    r_status <= ST_EMPTY;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            ACT_LOWER: begin
                                r_status <= ST_NOTFOUND;
                                r_state  <= S_SCAN;
                            end
                            default: begin
                                r_count <= '0;
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // One rotation: find target / fetch head and last entry.
                    unique case (r_act)
                        ACT_ENQ: begin
                            if ({1'b0, r_rot} == r_count) begin
                                r_sa <= r_rot; r_at <= r_tag; r_ap <= r_prio;
                                r_sb <= r_rot; r_bt <= r_tag; r_bp <= r_prio;
                                r_pos <= r_rot;
                            end
                        end
                        ACT_DEQ: begin
                            if (r_rot == '0) r_removed <= t_tag;
                            if ({1'b0, r_rot} == r_count - 1'b1) begin
                                r_at <= t_tag; r_ap <= t_prio;
                                r_bt <= t_tag; r_bp <= t_prio;
                            end
                            r_sa <= '0; r_sb <= '0; r_pos <= '0;
                        end
                        default: begin
                            if (w_hit) begin
                                r_found <= 1'b1;
                                r_pos   <= r_rot;
                                if (r_prio > t_prio) begin
                                    r_status <= ST_RAISED;
                                end else begin
                                    r_status <= ST_OK;
                                end
                            end
                        end
                    endcase
                    if (at_end) begin
                        priority if (r_act == ACT_ENQ) begin
                            r_swap  <= 1'b1;
                            r_count <= r_count + 1'b1;
                            r_state <= S_UP;
                        end else if (r_act == ACT_DEQ) begin
                            r_swap  <= 1'b1;
                            r_count <= r_count - 1'b1;
                            r_state <= S_DOWN;
                        end else if ((r_found && r_status == ST_OK)
                                     || (w_hit && r_prio <= t_prio)) begin
                            r_state <= S_UP;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_UP: begin
                    // Apply the pending swap and gather node and parent.
                    if (node_hit) begin
                        r_nt <= in_tag; r_np <= in_prio;
                    end
                    if (aux_hit) begin
                        r_lt <= in_tag; r_lp <= in_prio;
                    end
                    if (at_end) begin
                        if (r_pos != '0 && ahead_of(e_nt, e_np, e_lt, e_lp)) begin
                            r_swap <= 1'b1;
                            r_sa <= r_pos; r_at <= e_lt; r_ap <= e_lp;
                            r_sb <= w_parent; r_bt <= e_nt; r_bp <= e_np;
                            r_pos <= w_parent;
                        end else begin
                            r_swap  <= 1'b0;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DOWN: begin
                    // Apply the pending swap and gather node and both children.
                    if (node_hit) begin
                        r_nt <= in_tag; r_np <= in_prio;
                    end
                    if (aux_hit) begin
                        r_lt <= in_tag; r_lp <= in_prio;
                    end
                    if (right_hit) begin
                        r_rt <= in_tag; r_rp <= in_prio;
                    end
                    if (at_end) begin
                        priority if (w_rv && ahead_of(e_rt, e_rp, e_lt, e_lp)
                                     && ahead_of(e_rt, e_rp, e_nt, e_np)) begin
                            r_swap <= 1'b1;
                            r_sa <= r_pos; r_at <= e_rt; r_ap <= e_rp;
                            r_sb <= IW'(w_right); r_bt <= e_nt; r_bp <= e_np;
                            r_pos <= IW'(w_right);
                        end else if (w_lv && ahead_of(e_lt, e_lp, e_nt, e_np)) begin
                            r_swap <= 1'b1;
                            r_sa <= r_pos; r_at <= e_lt; r_ap <= e_lp;
                            r_sb <= IW'(w_left); r_bt <= e_nt; r_bp <= e_np;
                            r_pos <= IW'(w_left);
                        end else begin
                            r_swap  <= 1'b0;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    // The ring is stopped: r_rot is at 0, tail shows the root.
                    if (can_out) begin
                        r_ostatus <= r_status;
                        r_otag    <= (r_act == ACT_DEQ && r_status == ST_OK)
                                     ? 16'(r_removed) : 16'd0;
                        r_hvalid  <= (r_count != '0);
                        r_htag    <= (r_count != '0) ? 16'(t_tag) : 16'd0;
                        r_hprio   <= (r_count != '0) ? 16'(t_prio) : 16'd0;
                        r_ocount  <= 7'(r_count);
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_ovalid;
    assign o_status        = r_ostatus;
    assign o_out_tag       = r_otag;
    assign o_head_tag      = r_htag;
    assign o_head_priority = r_hprio;
    assign o_head_valid    = r_hvalid;
    assign o_count         = r_ocount;

    `AST_IMPL(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY), "count overflow")
    `AST_IMPL(a_rot_idle, i_clk, i_rst_n, r_state == S_IDLE, r_rot == '0, "ring misaligned")
    `AST_NEXT(a_hold, i_clk, i_rst_n, r_ovalid && i_stall, r_ovalid && $stable(r_ostatus),
              "result dropped")
endmodule
`default_nettype wire

FILE: hw/rtl/bhpq_cell.sv
// One heap slot: holds an entry and a valid bit, shifts toward the tail.
`default_nettype none
module bhpq_cell #(
    parameter int TAG_BITS = 16,
    parameter int PRIO_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  wire logic                 i_valid,
    input  wire logic [TAG_BITS-1:0]  i_tag,
    input  wire logic [PRIO_BITS-1:0] i_prio,
    output logic                      o_valid,
    output logic [TAG_BITS-1:0]       o_tag,
    output logic [PRIO_BITS-1:0]      o_prio
);
    logic                 r_valid;
    logic [TAG_BITS-1:0]  r_tag;
    logic [PRIO_BITS-1:0] r_prio;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_tag  <= i_tag;
            r_prio <= i_prio;
        end
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;
    assign o_prio  = r_prio;
endmodule
`default_nettype wire
